// ===== rtl/interest_rate_limit_controller_core_macros.svh =====
`ifndef INTEREST_RATE_LIMIT_CONTROLLER_CORE_MACROS_SVH
`define INTEREST_RATE_LIMIT_CONTROLLER_CORE_MACROS_SVH

// Both macros expect aclk and aresetn in scope.
`define IRLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define IRLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/irlc_pkg.sv =====
package irlc_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int SHARE_W   = 8;
    localparam int OUT_CNT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = DATA_W + SHARE_W;

    localparam logic [OP_W-1:0] OP_DATA  = 3'd0;
    localparam logic [OP_W-1:0] OP_EXTRA = 3'd1;
    localparam logic [OP_W-1:0] OP_NACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
    localparam logic [OP_W-1:0] OP_SENT  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MAX   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_STEP   = 2'd3;

    localparam logic [DATA_W-1:0] START_LIMIT_RESET = 32'd655360;
    localparam logic [DATA_W-1:0] FLOOR_LIMIT_RESET = 32'd6553600;
    localparam logic [DATA_W-1:0] ALPHA_MAX_RESET   = 32'd1310720;
    localparam logic [DATA_W-1:0] BETA_STEP_RESET   = 32'd72090;

    localparam int                 ALPHA_RESET_UNITS = 20;
    localparam logic [SHARE_W-1:0] SHARE_FULL        = 8'd100;
    localparam logic [DATA_W-1:0]  PERCENT_DIV       = 32'd100;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/irlc_div.sv =====
module irlc_div
    import irlc_pkg::*;
#(
    parameter int NUM_W = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DATA_W-1:0] den,
    output unit_stat_t        stat,
    output logic [DATA_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quot_reg, quot_next;
    logic              ovf_reg, ovf_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (busy_reg) begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            ovf_next  = ovf_reg | quot_reg[DATA_W-1];
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = diff[DATA_W-1:0];
                quot_next = {quot_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[DATA_W-1:0];
                quot_next = {quot_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = ovf_reg ? '1 : quot_reg;

endmodule

// ===== rtl/irlc_mul.sv =====
module irlc_mul
    import irlc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DATA_W-1:0]  mcand,
    input  logic [SHARE_W-1:0] mplier,
    output unit_stat_t         stat,
    output logic [PROD_W-1:0]  prod
);

    localparam int CNT_W = $clog2(SHARE_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0]  mc_reg, mc_next;
    logic [SHARE_W-1:0] mp_reg, mp_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        if (busy_reg) begin
            if (mp_reg[0]) begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = {mc_reg[PROD_W-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[SHARE_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SHARE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            mc_next   = PROD_W'(mcand);
            mp_next   = mplier;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

// ===== rtl/interest_rate_limit_controller_core.sv =====
// Rate limit controller: one word in gives one word out. A data word that is not a local
// hit runs two serial divisions by the current limit, one quotient bit per cycle in the
// shared divider. A partial-share nack runs a serial multiply and two divisions by 100.
// One word is in flight at a time; the result register lets the next word in while the
// previous result waits. Configuration writes are taken every cycle and must only be
// issued while the block is idle.
module interest_rate_limit_controller_core
    import irlc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_operation,
    input  logic                 s_local_hit,
    input  logic                 s_prefix_match,
    input  logic                 s_giveup_pit,
    input  logic [SHARE_W-1:0]   s_share_percent,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_rate_limit,
    output logic [DATA_W-1:0]    m_growth_step,
    output logic                 m_send_now,
    output logic                 m_report_valid,
    output logic [OUT_CNT_W-1:0] m_interests_sent,
    output logic [OUT_CNT_W-1:0] m_data_received,
    output logic [OUT_CNT_W-1:0] m_full_nacks,
    output logic [OUT_CNT_W-1:0] m_partial_nacks,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int EXT_W = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;
    localparam logic [DATA_W-1:0] ONE_FIX     = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0] ALPHA_RESET = DATA_W'(64'(ALPHA_RESET_UNITS) << FRAC_BITS);
    localparam logic [NUM_W-1:0]  ONE_SQ      = NUM_W'(1) << (2 * FRAC_BITS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DISP   = 4'd1;
    localparam logic [3:0] ST_D1W    = 4'd2;
    localparam logic [3:0] ST_D2S    = 4'd3;
    localparam logic [3:0] ST_D2W    = 4'd4;
    localparam logic [3:0] ST_MW     = 4'd5;
    localparam logic [3:0] ST_DBW    = 4'd6;
    localparam logic [3:0] ST_DAW    = 4'd7;
    localparam logic [3:0] ST_NAPPLY = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic [DATA_W-1:0]      start_limit_reg, start_limit_next;
    logic [DATA_W-1:0]      floor_limit_reg, floor_limit_next;
    logic [DATA_W-1:0]      alpha_max_reg, alpha_max_next;
    logic [DATA_W-1:0]      beta_step_reg, beta_step_next;
    logic [DATA_W-1:0]      limit_reg, limit_next;
    logic [DATA_W-1:0]      alpha_reg, alpha_next;
    logic                   started_reg, started_next;
    logic [DATA_W-1:0]      dec_reg, dec_next;
    logic [COUNT_WIDTH-1:0] sent_reg, sent_next;
    logic [COUNT_WIDTH-1:0] data_reg, data_next;
    logic [COUNT_WIDTH-1:0] full_reg, full_next;
    logic [COUNT_WIDTH-1:0] part_reg, part_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic                   hit_reg, hit_next;
    logic                   match_reg, match_next;
    logic                   giveup_reg, giveup_next;
    logic [SHARE_W-1:0]     share_reg, share_next;
    logic                   m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]      m_limit_reg, m_limit_next;
    logic [DATA_W-1:0]      m_alpha_reg, m_alpha_next;
    logic                   m_send_reg, m_send_next;
    logic                   m_report_reg, m_report_next;
    logic [OUT_CNT_W-1:0]   m_sent_reg, m_sent_next;
    logic [OUT_CNT_W-1:0]   m_data_reg, m_data_next;
    logic [OUT_CNT_W-1:0]   m_full_reg, m_full_next;
    logic [OUT_CNT_W-1:0]   m_part_reg, m_part_next;

    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DATA_W-1:0] div_den;
    unit_stat_t        div_stat;
    logic [DATA_W-1:0] div_quot;
    logic              mul_start;
    unit_stat_t        mul_stat;
    logic [PROD_W-1:0] mul_prod;

    logic              nack_taken;
    logic              share_full;
    logic [DATA_W-1:0] alpha_eff;
    logic [DATA_W-1:0] alpha_sum;
    logic [DATA_W-1:0] lim_sub;

    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
        logic [DATA_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DATA_W] ? '1 : sum[DATA_W-1:0];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic [OUT_CNT_W-1:0] show(input logic [COUNT_WIDTH-1:0] c);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(c);
        return (ext > EXT_W'({OUT_CNT_W{1'b1}})) ? '1 : ext[OUT_CNT_W-1:0];
    endfunction

    irlc_div #(
        .NUM_W(NUM_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .stat   (div_stat),
        .quot   (div_quot)
    );

    irlc_mul u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .mcand  (beta_step_reg),
        .mplier (share_reg),
        .stat   (mul_stat),
        .prod   (mul_prod)
    );

    assign nack_taken = match_reg && giveup_reg;
    assign share_full = share_reg >= SHARE_FULL;
    assign alpha_eff  = started_reg ? alpha_reg : alpha_max_reg;
    assign alpha_sum  = sat_add(alpha_reg, div_quot);
    assign lim_sub    = (limit_reg > dec_reg) ? limit_reg - dec_reg : '0;

    always_comb begin
        div_start = 1'b0;
        div_num   = {alpha_eff, {FRAC_BITS{1'b0}}};
        div_den   = PERCENT_DIV;
        mul_start = 1'b0;
        case (state_reg)
            ST_DISP: begin
                div_start = (op_reg == OP_DATA) && !hit_reg;
                div_den   = limit_reg;
                mul_start = (op_reg == OP_NACK) && nack_taken && !share_full;
            end
            ST_D2S: begin
                div_start = 1'b1;
                div_num   = ONE_SQ;
                div_den   = limit_reg;
            end
            ST_MW: begin
                div_start = mul_stat.done;
                div_num   = NUM_W'(mul_prod);
            end
            ST_DBW: begin
                div_start = div_stat.done;
                div_num   = NUM_W'({share_reg, {FRAC_BITS{1'b0}}});
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        start_limit_next = start_limit_reg;
        floor_limit_next = floor_limit_reg;
        alpha_max_next   = alpha_max_reg;
        beta_step_next   = beta_step_reg;
        limit_next       = limit_reg;
        alpha_next       = alpha_reg;
        started_next     = started_reg;
        dec_next         = dec_reg;
        sent_next        = sent_reg;
        data_next        = data_reg;
        full_next        = full_reg;
        part_next        = part_reg;
        op_next          = op_reg;
        hit_next         = hit_reg;
        match_next       = match_reg;
        giveup_next      = giveup_reg;
        share_next       = share_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_limit_next     = m_limit_reg;
        m_alpha_next     = m_alpha_reg;
        m_send_next      = m_send_reg;
        m_report_next    = m_report_reg;
        m_sent_next      = m_sent_reg;
        m_data_next      = m_data_reg;
        m_full_next      = m_full_reg;
        m_part_next      = m_part_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_operation;
                    hit_next    = s_local_hit;
                    match_next  = s_prefix_match;
                    giveup_next = s_giveup_pit;
                    share_next  = s_share_percent;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP: begin
                state_next = ST_FIN;
                case (op_reg)
                    OP_DATA: begin
                        started_next = 1'b1;
                        alpha_next   = alpha_eff;
                        if (!hit_reg) begin
                            state_next = ST_D1W;
                        end
                    end
                    OP_NACK: begin
                        if (nack_taken && share_full) begin
                            dec_next   = beta_step_reg;
                            state_next = ST_NAPPLY;
                        end else if (nack_taken) begin
                            state_next = ST_MW;
                        end
                    end
                    default: begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_D1W: begin
                if (div_stat.done) begin
                    limit_next = sat_add(limit_reg, div_quot);
                    state_next = ST_D2S;
                end
            end
            ST_D2S: begin
                state_next = ST_D2W;
            end
            ST_D2W: begin
                if (div_stat.done) begin
                    alpha_next = (alpha_sum > alpha_max_reg) ? alpha_max_reg : alpha_sum;
                    state_next = ST_FIN;
                end
            end
            ST_MW: begin
                if (mul_stat.done) begin
                    state_next = ST_DBW;
                end
            end
            ST_DBW: begin
                if (div_stat.done) begin
                    dec_next   = div_quot;
                    state_next = ST_DAW;
                end
            end
            ST_DAW: begin
                if (div_stat.done) begin
                    alpha_next = (alpha_reg <= div_quot) ? ONE_FIX : alpha_reg - div_quot;
                    state_next = ST_NAPPLY;
                end
            end
            ST_NAPPLY: begin
                limit_next = (lim_sub <= floor_limit_reg) ? floor_limit_reg : lim_sub;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    case (op_reg)
                        OP_DATA: begin
                            data_next = bump(data_reg);
                        end
                        OP_EXTRA: begin
                            if (match_reg) begin
                                data_next = bump(data_reg);
                            end
                        end
                        OP_NACK: begin
                            if (nack_taken && share_full) begin
                                full_next = bump(full_reg);
                            end else if (nack_taken) begin
                                part_next = bump(part_reg);
                            end
                        end
                        OP_TICK: begin
                            sent_next = '0;
                            data_next = '0;
                            full_next = '0;
                            part_next = '0;
                        end
                        OP_SENT: begin
                            sent_next = bump(sent_reg);
                        end
                        default: begin
                            sent_next = sent_reg;
                        end
                    endcase
                    m_valid_next  = 1'b1;
                    m_limit_next  = limit_reg;
                    m_alpha_next  = alpha_reg;
                    m_send_next   = (op_reg == OP_DATA) && hit_reg;
                    m_report_next = op_reg == OP_TICK;
                    if (op_reg == OP_TICK) begin
                        m_sent_next = show(sent_reg);
                        m_data_next = show(data_reg);
                        m_full_next = show(full_reg);
                        m_part_next = show(part_reg);
                    end else begin
                        m_sent_next = show(sent_next);
                        m_data_next = show(data_next);
                        m_full_next = show(full_next);
                        m_part_next = show(part_next);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            case (cfg_index)
                CFG_START_LIMIT: begin
                    start_limit_next = cfg_data;
                    limit_next       = cfg_data;
                end
                CFG_FLOOR_LIMIT: floor_limit_next = cfg_data;
                CFG_ALPHA_MAX:   alpha_max_next   = cfg_data;
                CFG_BETA_STEP:   beta_step_next   = cfg_data;
                default:         beta_step_next   = beta_step_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            start_limit_reg <= START_LIMIT_RESET;
            floor_limit_reg <= FLOOR_LIMIT_RESET;
            alpha_max_reg   <= ALPHA_MAX_RESET;
            beta_step_reg   <= BETA_STEP_RESET;
            limit_reg       <= START_LIMIT_RESET;
            alpha_reg       <= ALPHA_RESET;
            started_reg     <= 1'b0;
            sent_reg        <= '0;
            data_reg        <= '0;
            full_reg        <= '0;
            part_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            start_limit_reg <= start_limit_next;
            floor_limit_reg <= floor_limit_next;
            alpha_max_reg   <= alpha_max_next;
            beta_step_reg   <= beta_step_next;
            limit_reg       <= limit_next;
            alpha_reg       <= alpha_next;
            started_reg     <= started_next;
            sent_reg        <= sent_next;
            data_reg        <= data_next;
            full_reg        <= full_next;
            part_reg        <= part_next;
            m_valid_reg     <= m_valid_next;
        end
        dec_reg      <= dec_next;
        op_reg       <= op_next;
        hit_reg      <= hit_next;
        match_reg    <= match_next;
        giveup_reg   <= giveup_next;
        share_reg    <= share_next;
        m_limit_reg  <= m_limit_next;
        m_alpha_reg  <= m_alpha_next;
        m_send_reg   <= m_send_next;
        m_report_reg <= m_report_next;
        m_sent_reg   <= m_sent_next;
        m_data_reg   <= m_data_next;
        m_full_reg   <= m_full_next;
        m_part_reg   <= m_part_next;
    end

    assign s_ready          = state_reg == ST_IDLE;
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_rate_limit     = m_limit_reg;
    assign m_growth_step    = m_alpha_reg;
    assign m_send_now       = m_send_reg;
    assign m_report_valid   = m_report_reg;
    assign m_interests_sent = m_sent_reg;
    assign m_data_received  = m_data_reg;
    assign m_full_nacks     = m_full_reg;
    assign m_partial_nacks  = m_part_reg;

endmodule

// ===== rtl/irlc_checker.sv =====
`include "interest_rate_limit_controller_core_macros.svh"

module irlc_checker
    import irlc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [DATA_W-1:0]    m_rate_limit,
    input logic [DATA_W-1:0]    m_growth_step,
    input logic                 m_send_now,
    input logic                 m_report_valid
);

    // A stalled result word must hold its value.
    `IRLC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_rate_limit) && $stable(m_growth_step), "stalled result changed")

    // Only a data word raises send_now, so a report never carries it.
    `IRLC_ASSERT_NOW(a_report_no_send, m_valid && m_report_valid, !m_send_now,
        "report word with send_now set")

    // The block works on one word at a time.
    `IRLC_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready,
        "input taken again straight after a word was accepted")

endmodule

bind interest_rate_limit_controller_core irlc_checker u_irlc_checker (.*);
